// ----- sv/bddcl_pkg.sv -----
// bddcl_pkg: constants and the atan table shared by the bpsk carrier loop files
`default_nettype none

package bddcl_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOOP_ALPHA   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_PHASE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_FREQ   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_OFFSET = 3'd4;

  localparam int GUARD        = 8;
  localparam int CORDIC_ITERS = 16;
  localparam int ITER_W       = 4;
  localparam int MUL_B_W      = 31;
  localparam int IDX_W        = 16;

  localparam logic [IDX_W-1:0]          IDX_MAX    = 16'hFFFF;
  localparam logic signed [MUL_B_W-1:0] INV_GAIN   = 31'sd39797;
  localparam logic signed [MUL_B_W-1:0] INV_TWO_PI = 31'sd683565276;

  // atan(2^-k) in turns, 2^32 per turn
  localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

endpackage

`default_nettype wire

// ----- sv/bddcl_if.sv -----
// bddcl_if: handshake channels of the bpsk carrier loop
`default_nettype none

interface bddcl_sym_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sym_i;
  logic signed [SAMPLE_WIDTH-1:0] sym_q;
  logic                           burst_start;

  modport source (output valid, sym_i, sym_q, burst_start, input ready);
  modport sink (input valid, sym_i, sym_q, burst_start, output ready);
endinterface

interface bddcl_res_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_i;
  logic signed [SAMPLE_WIDTH-1:0] out_q;
  logic                           tracking;

  modport source (output valid, out_i, out_q, tracking, input ready);
  modport sink (input valid, out_i, out_q, tracking, output ready);
endinterface

interface bddcl_cfg_if import bddcl_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/bpsk_decision_directed_carrier_loop.sv -----
// bpsk_decision_directed_carrier_loop: cordic derotator with a second-order decision loop
//
//   channel  modport  payload                          transfer when
//   cfg      sink     index, data                      cfg.valid && cfg.ready
//   sym      sink     sym_i, sym_q, burst_start        sym.valid && sym.ready
//   res      source   out_i, out_q, tracking           res.valid && res.ready
//
// one symbol at a time: sym.ready is high only while the sequencer is idle
// tracked symbol: prep, cordic steps, gain scaling, loop update; open-loop symbol: no update
// burst start adds restart steps; bypassed symbol (enable low): straight to the result step
// the 16 cordic steps run on one shift-add unit; the other steps use the shared multiplier
// the result register frees the datapath; a stalled result only holds the final step
// rst is synchronous; config and loop state return to zero, no clearing pass
`default_nettype none

module bpsk_decision_directed_carrier_loop import bddcl_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int PHASE_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  bddcl_cfg_if.sink   cfg,
  bddcl_sym_if.sink   sym,
  bddcl_res_if.source res
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int PW  = PHASE_WIDTH;
  localparam int XW  = SW + GUARD + 3;
  localparam int RW  = SW + 2;
  localparam int MA0 = (PW > XW) ? PW : XW;
  localparam int MA  = (MA0 > 32) ? MA0 : 32;
  localparam int PRW = MA + MUL_B_W;
  localparam int TPL = (PW >= 32) ? PW - 32 : 0;
  localparam int TPR = (PW < 32) ? 32 - PW : 0;

  localparam logic signed [RW-1:0] SAT_HI = RW'((2 ** (SW - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [RW:0]   ONE_E  = (RW + 1)'(2 ** (SW - 2));

  typedef enum logic [3:0] {
    S_IDLE, S_BURST, S_OPEN, S_PREP, S_ROT, S_MX, S_MY, S_RQ,
    S_CLAMP, S_ME, S_E32, S_MF, S_FREQ, S_PHASE, S_FIN
  } state_t;

  state_t state;

  logic                     enable;
  logic [15:0]              loop_alpha;
  logic [15:0]              start_phase;
  logic signed [31:0]       start_freq;
  logic [15:0]              frame_offset;

  logic [IDX_W-1:0]         symbol_index;
  logic [PW-1:0]            loop_phase;
  logic [PW-1:0]            loop_freq;
  logic [PW-1:0]            open_phase;

  logic signed [SW-1:0]     xin;
  logic signed [SW-1:0]     yin;
  logic                     trk;
  logic                     upd;
  logic [ITER_W-1:0]        k;
  logic signed [XW-1:0]     x;
  logic signed [XW-1:0]     y;
  logic signed [31:0]       r;
  logic signed [PRW-1:0]    prod;
  logic signed [MUL_B_W-1:0] beta;
  logic signed [RW-1:0]     ri;
  logic signed [RW-1:0]     rq;
  logic signed [SW-1:0]     err;
  logic signed [31:0]       e32;

  logic                     res_valid;
  logic signed [SW-1:0]     res_i;
  logic signed [SW-1:0]     res_q;
  logic                     res_trk;

  function automatic logic signed [PRW-1:0] rshr(input logic signed [PRW-1:0] v,
                                                  input int n);
    logic signed [PRW-1:0] half;
    half = '0;
    half[n-1] = 1'b1;
    return (v + half) >>> n;
  endfunction

  function automatic logic [PW-1:0] tp(input logic signed [PRW-1:0] v);
    logic signed [PRW-1:0] s;
    if (TPR == 0) begin
      s = v <<< TPL;
    end else begin
      s = rshr(v, TPR);
    end
    return s[PW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sat(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] s;
    if (v > SAT_HI) begin
      s = SAT_HI;
    end else if (v < SAT_LO) begin
      s = SAT_LO;
    end else begin
      s = v;
    end
    return s[SW-1:0];
  endfunction

  // handshakes
  logic sym_xfer;
  logic cfg_xfer;
  logic res_free;

  assign sym.ready = (state == S_IDLE) && !rst;
  assign cfg.ready = !rst;
  assign sym_xfer  = sym.valid && sym.ready;
  assign cfg_xfer  = cfg.valid && cfg.ready;
  assign res_free  = !res_valid || res.ready;

  assign res.valid    = res_valid;
  assign res.out_i    = res_i;
  assign res.out_q    = res_q;
  assign res.tracking = res_trk;

  // start values and angle preparation
  logic [PW-1:0]         sf;
  logic [PW-1:0]         sp;
  logic                  trk_c;
  logic [PW-1:0]         phase_sel;
  logic [PW-1:0]         a_neg;
  logic [PW+31:0]        a_wide;
  logic [31:0]           a32;
  logic [31:0]           a_bias;
  logic [1:0]            quad;
  logic [31:0]           r0;
  logic signed [XW-1:0]  x0;
  logic signed [XW-1:0]  y0;
  logic signed [XW-1:0]  xq;
  logic signed [XW-1:0]  yq;

  always_comb begin
    sf        = tp(PRW'(start_freq));
    sp        = PW'(start_phase) << (PW - 16);
    trk_c     = symbol_index >= frame_offset;
    phase_sel = trk_c ? loop_phase : open_phase;
    a_neg     = -phase_sel;
    a_wide    = {a_neg, 32'd0};
    a32       = a_wide[PW+31:PW];
    a_bias    = a32 + 32'h2000_0000;
    quad      = a_bias[31:30];
    r0        = a32 - {quad, 30'd0};
    x0        = XW'(xin) <<< GUARD;
    y0        = XW'(yin) <<< GUARD;
    case (quad)
      2'd1: begin
        xq = -y0;
        yq = x0;
      end
      2'd2: begin
        xq = -x0;
        yq = -y0;
      end
      2'd3: begin
        xq = y0;
        yq = -x0;
      end
      default: begin
        xq = x0;
        yq = y0;
      end
    endcase
  end

  // cordic shift-add step
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [31:0]   atan_k;

  assign dx     = y >>> k;
  assign dy     = x >>> k;
  assign atan_k = ATAN_TAB[k];

  // error decision and clamp
  logic signed [RW:0] er;
  logic signed [RW:0] er_c;

  always_comb begin
    er = ri[RW-1] ? -((RW + 1)'(rq)) : (RW + 1)'(rq);
    if (er > ONE_E) begin
      er_c = ONE_E;
    end else if (er < -ONE_E) begin
      er_c = -ONE_E;
    end else begin
      er_c = er;
    end
  end

  // shared multiplier
  logic signed [MA-1:0]      mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_en;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (state)
      S_BURST: begin
        mul_a = MA'(signed'(sf));
        mul_b = MUL_B_W'({1'b0, frame_offset});
      end
      S_PREP: begin
        mul_a = MA'({1'b0, loop_alpha});
        mul_b = MUL_B_W'({1'b0, loop_alpha});
      end
      S_MX: begin
        mul_a = MA'(x);
        mul_b = INV_GAIN;
      end
      S_MY: begin
        mul_a = MA'(y);
        mul_b = INV_GAIN;
      end
      S_ME: begin
        mul_a = MA'(err);
        mul_b = INV_TWO_PI;
      end
      S_MF: begin
        mul_a = MA'(e32);
        mul_b = beta;
      end
      S_FREQ: begin
        mul_a = MA'(e32);
        mul_b = MUL_B_W'({1'b0, loop_alpha});
      end
      default: mul_en = 1'b0;
    endcase
  end

  // rounded views of the product
  logic signed [PRW-1:0] rnd_g;
  logic signed [PRW-1:0] rnd_e;
  logic signed [PRW-1:0] rnd_f;
  logic signed [PRW-1:0] rnd_p;
  logic [PRW-1:0]        beta_w;

  always_comb begin
    rnd_g  = rshr(prod, 16 + GUARD);
    rnd_e  = rshr(prod, SW - 2);
    rnd_f  = rshr(prod, 32);
    rnd_p  = rshr(prod, 16);
    beta_w = prod >> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      enable       <= 1'b0;
      loop_alpha   <= '0;
      start_phase  <= '0;
      start_freq   <= '0;
      frame_offset <= '0;
      symbol_index <= '0;
      loop_phase   <= '0;
      loop_freq    <= '0;
      open_phase   <= '0;
      res_valid    <= 1'b0;
      k            <= '0;
    end else begin
      if (cfg_xfer) begin
        case (cfg.index)
          REG_ENABLE:       enable       <= cfg.data[0];
          REG_LOOP_ALPHA:   loop_alpha   <= cfg.data[15:0];
          REG_START_PHASE:  start_phase  <= cfg.data[15:0];
          REG_START_FREQ:   start_freq   <= cfg.data[31:0];
          REG_FRAME_OFFSET: frame_offset <= cfg.data[15:0];
          default: ;
        endcase
      end

      if (mul_en) begin
        prod <= mul_a * mul_b;
      end

      // the final step reloads the register itself when it is taken
      if (res_valid && res.ready && state != S_FIN) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sym_xfer) begin
            xin <= sym.sym_i;
            yin <= sym.sym_q;
            if (!enable) begin
              ri    <= RW'(sym.sym_i);
              rq    <= RW'(sym.sym_q);
              trk   <= 1'b0;
              upd   <= 1'b0;
              state <= S_FIN;
            end else if (sym.burst_start) begin
              state <= S_BURST;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_BURST: begin
          symbol_index <= '0;
          loop_phase   <= sp;
          loop_freq    <= sf;
          state        <= S_OPEN;
        end
        S_OPEN: begin
          open_phase <= sp - prod[PW-1:0];
          state      <= S_PREP;
        end
        S_PREP: begin
          trk   <= trk_c;
          upd   <= 1'b1;
          x     <= xq;
          y     <= yq;
          r     <= r0;
          k     <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (!r[31]) begin
            x <= x - dx;
            y <= y + dy;
            r <= r - atan_k;
          end else begin
            x <= x + dx;
            y <= y - dy;
            r <= r + atan_k;
          end
          k <= k + ITER_W'(1);
          if (k == ITER_W'(CORDIC_ITERS - 1)) begin
            state <= S_MX;
          end
        end
        S_MX: begin
          beta  <= beta_w[MUL_B_W-1:0];
          state <= S_MY;
        end
        S_MY: begin
          ri    <= rnd_g[RW-1:0];
          state <= S_RQ;
        end
        S_RQ: begin
          rq <= rnd_g[RW-1:0];
          if (trk) begin
            state <= S_CLAMP;
          end else begin
            open_phase <= open_phase + sf;
            state      <= S_FIN;
          end
        end
        S_CLAMP: begin
          err   <= er_c[SW-1:0];
          state <= S_ME;
        end
        S_ME: begin
          state <= S_E32;
        end
        S_E32: begin
          e32   <= rnd_e[31:0];
          state <= S_MF;
        end
        S_MF: begin
          state <= S_FREQ;
        end
        S_FREQ: begin
          loop_freq <= loop_freq + tp(rnd_f);
          state     <= S_PHASE;
        end
        S_PHASE: begin
          loop_phase <= loop_phase + tp(rnd_p) + loop_freq;
          state      <= S_FIN;
        end
        S_FIN: begin
          if (res_free) begin
            res_valid <= 1'b1;
            res_i     <= sat(ri);
            res_q     <= sat(rq);
            res_trk   <= trk;
            if (upd && symbol_index != IDX_MAX) begin
              symbol_index <= symbol_index + IDX_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    sym_xfer |=> (state != S_IDLE))
    else $error("accepted symbol did not start the sequencer");

  a_bypass_direct: assert property (@(posedge clk) disable iff (rst)
    (sym_xfer && !enable) |=> (state == S_FIN && !trk && !upd))
    else $error("bypassed symbol did not go straight to the result step");

  a_rot_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT && k == ITER_W'(CORDIC_ITERS - 1)) |=> (state == S_MX))
    else $error("cordic did not end after its last step");

  a_open_skips_loop: assert property (@(posedge clk) disable iff (rst)
    (state == S_RQ && !trk) |=> (state == S_FIN))
    else $error("open-loop symbol entered the loop update");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res_free) |=> (res_valid && state == S_IDLE))
    else $error("result not loaded when the output register was free");

endmodule

`default_nettype wire

// ----- tb/bpsk_decision_directed_carrier_loop_tb.sv -----
// self-checking bench for the bpsk carrier loop: predicts each derotated symbol and checks it
`default_nettype none

module bpsk_decision_directed_carrier_loop_tb import bddcl_pkg::*;;

  typedef struct {
    logic signed [15:0] out_i;
    logic signed [15:0] out_q;
    logic               tracking;
  } derot_sym_t;

  class carrier_loop_board;
    bit         en;
    bit  [15:0] alpha, sphase, foffset;
    bit  [31:0] sfreq;
    bit  [15:0] sym_idx;
    bit  [31:0] lphase, lfreq, ophase;
    derot_sym_t derotated_q[$];
    int         errors;
    int         checked;

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ENABLE:       en      = data[0];
        REG_LOOP_ALPHA:   alpha   = data[15:0];
        REG_START_PHASE:  sphase  = data[15:0];
        REG_START_FREQ:   sfreq   = data;
        REG_FRAME_OFFSET: foffset = data[15:0];
        default: ;
      endcase
    endfunction

    function longint round_half_up(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function logic signed [15:0] saturate(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    // cordic rotation by -ph, rounded but not saturated
    function void derotate(input longint xi, yi, input bit [31:0] ph,
                           output longint ox, oy);
      bit [31:0] ang, rem;
      bit [1:0]  quad;
      longint    x, y, r, t, dx, dy;
      ang  = -ph;
      quad = 2'((ang + 32'h20000000) >> 30);
      rem  = ang - {quad, 30'b0};
      r    = longint'($signed(rem));
      x    = xi * 256;
      y    = yi * 256;
      if (quad == 2'd1) begin
        t = x; x = -y; y = t;
      end else if (quad == 2'd2) begin
        x = -x; y = -y;
      end else if (quad == 2'd3) begin
        t = x; x = y; y = -t;
      end
      for (int k = 0; k < CORDIC_ITERS; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (r >= 0) begin
          x -= dx; y += dy; r -= longint'(ATAN_TAB[k]);
        end else begin
          x += dx; y -= dy; r += longint'(ATAN_TAB[k]);
        end
      end
      ox = round_half_up(x * longint'(INV_GAIN), 16 + GUARD);
      oy = round_half_up(y * longint'(INV_GAIN), 16 + GUARD);
    endfunction

    function void note_symbol(logic signed [15:0] si, sq, logic bs);
      derot_sym_t e;
      longint     ri, rq, err, e32, beta;
      bit [31:0]  sp;
      if (!en) begin
        e.out_i = si; e.out_q = sq; e.tracking = 1'b0;
        derotated_q = {derotated_q, e};
        return;
      end
      if (bs) begin
        sp      = {sphase, 16'h0000};
        sym_idx = '0;
        lphase  = sp;
        lfreq   = sfreq;
        ophase  = sp - sfreq * {16'h0000, foffset};
      end
      e.tracking = 1'b0;
      if (sym_idx < foffset) begin
        derotate(si, sq, ophase, ri, rq);
        ophase = ophase + sfreq;
      end else begin
        derotate(si, sq, lphase, ri, rq);
        err = (ri >= 0) ? rq : -rq;
        if (err > 16384) err = 16384;
        if (err < -16384) err = -16384;
        e32    = round_half_up(err * longint'(INV_TWO_PI), 14);
        beta   = (longint'(alpha) * longint'(alpha)) >>> 2;
        lfreq  = lfreq + 32'(round_half_up(beta * e32, 32));
        lphase = lphase + 32'(round_half_up(longint'(alpha) * e32, 16)) + lfreq;
        e.tracking = 1'b1;
      end
      if (sym_idx != IDX_MAX) sym_idx++;
      e.out_i = saturate(ri);
      e.out_q = saturate(rq);
      derotated_q = {derotated_q, e};
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $time, what);
    endtask

    task check_symbol(logic signed [15:0] oi, oq, logic trk);
      derot_sym_t e;
      if (derotated_q.size() == 0) begin
        report($sformatf("result %0d (%0d, %0d, %0b) with none expected",
                         checked, oi, oq, trk));
        checked++;
        return;
      end
      e = derotated_q.pop_front();
      if (oi !== e.out_i)
        report($sformatf("result %0d out_i %0d, expected %0d", checked, oi, e.out_i));
      if (oq !== e.out_q)
        report($sformatf("result %0d out_q %0d, expected %0d", checked, oq, e.out_q));
      if (trk !== e.tracking)
        report($sformatf("result %0d tracking %0b, expected %0b", checked, trk, e.tracking));
      checked++;
    endtask
  endclass

  logic clk;
  logic rst;
  int   steady_left;

  carrier_loop_board board = new();

  bddcl_cfg_if cfg ();
  bddcl_sym_if #(.SAMPLE_WIDTH(16)) sym ();
  bddcl_res_if #(.SAMPLE_WIDTH(16)) res ();

  bpsk_decision_directed_carrier_loop #(
    .SAMPLE_WIDTH(16),
    .PHASE_WIDTH (32)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .sym(sym),
    .res(res)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) board.check_symbol(res.out_i, res.out_q, res.tracking);
  end

  task automatic send_symbol(input logic signed [15:0] si, sq, input logic bs, input bit last);
    int gap, pick;
    sym.valid       <= 1'b1;
    sym.sym_i       <= si;
    sym.sym_q       <= sq;
    sym.burst_start <= bs;
    do @(posedge clk); while (!sym.ready);
    board.note_symbol(si, sq, bs);
    if (last) begin
      gap = 1;
    end else if (steady_left > 0) begin
      steady_left--;
      gap = 0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        steady_left = $urandom_range(20, 60);
        gap = 0;
      end else if (pick < 45) begin
        gap = 0;
      end else if (pick < 90) begin
        gap = $urandom_range(1, 4);
      end else begin
        gap = $urandom_range(10, 60);
      end
    end
    if (gap > 0) begin
      sym.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic apply_settings(input bit en, input bit [15:0] alpha, sp,
                                input bit [31:0] sf, input bit [15:0] fo);
    logic [CFG_INDEX_W-1:0] idxs [5];
    logic [CFG_DATA_W-1:0]  vals [5];
    idxs = '{REG_ENABLE, REG_LOOP_ALPHA, REG_START_PHASE, REG_START_FREQ, REG_FRAME_OFFSET};
    vals = '{32'(en), 32'(alpha), 32'(sp), sf, 32'(fo)};
    for (int k = 0; k < 5; k++) begin
      cfg.valid <= 1'b1;
      cfg.index <= idxs[k];
      cfg.data  <= vals[k];
      do @(posedge clk); while (!cfg.ready);
      board.write_reg(idxs[k], vals[k]);
    end
    cfg.valid <= 1'b0;
  endtask

  task automatic settle();
    while (board.derotated_q.size() != 0) @(posedge clk);
  endtask

  // result side: steady, choppy and stalled stretches, plus one long hold
  initial begin : result_sink
    int span, mode;
    bit held;
    res.ready = 1'b0;
    held      = 1'b0;
    forever begin
      if (!held && board.checked >= 250) begin
        held = 1'b1;
        res.ready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      mode = $urandom_range(0, 9);
      if (mode < 4) span = $urandom_range(20, 200);
      else if (mode < 7) span = $urandom_range(5, 60);
      else if (mode < 9) span = $urandom_range(1, 6);
      else span = $urandom_range(30, 120);
      repeat (span) begin
        if (mode < 4) res.ready <= 1'b1;
        else if (mode < 7) res.ready <= ($urandom_range(0, 3) != 0);
        else res.ready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin : limit
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic signed [15:0] si, sq;
    logic               bs;
    int                 burst_left, amp, pick;
    bit                 en_v;
    bit [15:0]          alpha_v, sp_v, fo_v;
    bit [31:0]          sf_v;
    clk             = 1'b0;
    rst             = 1'b1;
    steady_left     = 0;
    sym.valid       = 1'b0;
    sym.sym_i       = '0;
    sym.sym_q       = '0;
    sym.burst_start = 1'b0;
    cfg.valid       = 1'b0;
    cfg.index       = '0;
    cfg.data        = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // disabled after reset: pass-through, burst start ignored
    send_symbol(32767, -32768, 1, 0);
    send_symbol(-32768, 32767, 1, 0);
    send_symbol(0, -1, 0, 1);
    settle();

    // no burst start yet: loop runs from zero phase and frequency
    apply_settings(1, 16'h2000, 16'h4000, 32'h0, 16'd0);
    send_symbol(16384, 0, 0, 0);
    send_symbol(-32768, -32768, 0, 0);
    send_symbol(0, 0, 0, 0);
    send_symbol(32767, 32767, 0, 0);
    send_symbol(32767, 32767, 1, 0);
    send_symbol(-16384, 100, 0, 0);
    send_symbol(12000, -20000, 0, 0);
    send_symbol(0, 16384, 0, 1);
    settle();

    // open loop then tracking, full gain, phase and frequency wrap
    apply_settings(1, 16'hFFFF, 16'hFFFF, 32'h80000000, 16'd3);
    send_symbol(16000, 3000, 1, 0);
    send_symbol(-16000, -3000, 0, 0);
    send_symbol(-32768, 0, 0, 0);
    send_symbol(16000, 16000, 0, 0);
    send_symbol(-5, 7, 0, 0);
    send_symbol(32767, -32767, 1, 0);
    send_symbol(100, -100, 0, 0);
    send_symbol(16384, -16384, 0, 1);
    settle();

    // disabled mid-burst: state must be kept
    apply_settings(0, 16'h1234, 16'h8000, 32'h7FFFFFFF, 16'd2);
    send_symbol(1234, -4321, 1, 0);
    send_symbol(-32768, -32768, 1, 0);
    send_symbol(32767, 32767, 0, 1);
    settle();
    apply_settings(1, 16'h1234, 16'h8000, 32'h7FFFFFFF, 16'd2);
    send_symbol(20000, -1000, 0, 0);
    send_symbol(-20000, 1000, 0, 0);
    send_symbol(9000, 9000, 1, 1);
    settle();

    for (int p = 0; p < 8; p++) begin
      en_v = (p != 3);
      if (p == 0) begin
        alpha_v = 16'hFFFF; sp_v = 16'($urandom); sf_v = 32'h7FFFFFFF; fo_v = 16'd0;
      end else if (p == 1) begin
        alpha_v = 16'h0000; sp_v = 16'hFFFF; sf_v = 32'h80000000; fo_v = 16'hFFFF;
      end else begin
        pick = $urandom_range(0, 3);
        if (pick == 0) alpha_v = 16'($urandom);
        else if (pick == 3) alpha_v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else alpha_v = 16'($urandom_range(1024, 16384));
        sp_v = 16'($urandom);
        pick = $urandom_range(0, 2);
        if (pick == 0) sf_v = $urandom;
        else if (pick == 1) sf_v = $urandom_range(0, 32'h00800000) - 32'h00400000;
        else sf_v = 32'h0;
        fo_v = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 40));
      end
      apply_settings(en_v, alpha_v, sp_v, sf_v, fo_v);
      burst_left = 0;
      for (int n = 0; n < 190; n++) begin
        if (burst_left == 0) begin
          bs = 1'b1;
          burst_left = $urandom_range(1, 80);
        end else begin
          bs = ($urandom_range(0, 39) == 0);
        end
        burst_left--;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          si = 16'($urandom);
          sq = 16'($urandom);
        end else begin
          amp = $urandom_range(2000, 18000);
          si  = 16'($urandom_range(0, 1) ? amp : -amp);
          sq  = 16'(int'($urandom_range(0, 8000)) - 4000);
        end
        send_symbol(si, sq, bs, n == 189);
      end
      settle();
    end

    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.derotated_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
